@@ sv/shw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// shw_pkg
// Shared constants, types and the coefficient tables of the stereo widener.
// ----------------------------------------------------------------------------
package shw_pkg;

    localparam int TAPS        = 128;
    localparam int ADDR_W      = $clog2(TAPS);
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_W      = 16;
    localparam int ACC_W       = SAMPLE_BITS + COEF_W + ADDR_W;
    localparam int SAT_W       = ACC_W + 2;
    localparam int RATE_W      = 18;
    localparam int WIDTH_W     = 16;
    localparam int CFG_DATA_W  = 18;

    localparam logic [RATE_W-1:0]  RATE_RESET = RATE_W'(48000);
    localparam logic [WIDTH_W:0]   WIDTH_FULL = (WIDTH_W+1)'(32768);
    localparam logic [14:0]        SHELF_K    = 15'd9830;

    typedef enum logic {
        CFG_WIDTH = 1'b0,
        CFG_RATE  = 1'b1
    } t_cfg_index;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef t_coef [TAPS-1:0] t_coef_rom;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned RIGHT_PHASE = 64'd1717986918;

    function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        hi = SAT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
        lo = -hi - SAT_W'(1);
        if (v > hi) return hi[SAMPLE_BITS-1:0];
        if (v < lo) return lo[SAMPLE_BITS-1:0];
        return v[SAMPLE_BITS-1:0];
    endfunction

    // e^-(16z), z in Q30
    function automatic longint unsigned exp_neg16(input longint unsigned z);
        longint unsigned t;
        t = Q30_ONE - z / 5;
        t = Q30_ONE - ((z * t) >> 30) / 4;
        t = Q30_ONE - ((z * t) >> 30) / 3;
        t = Q30_ONE - ((z * t) >> 30) / 2;
        t = Q30_ONE - ((z * t) >> 30);
        for (int k = 0; k < 4; k++) t = (t * t) >> 30;
        return t;
    endfunction

    function automatic t_coef make_coef(input longint unsigned win,
                                        input longint unsigned phase);
        longint unsigned q;
        longint unsigned f;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned m;
        q = (phase >> 30) & 64'd3;
        f = phase & 64'h3FFF_FFFF;
        if (q[0]) f = Q30_ONE - f;
        x  = (f * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t = Q30_ONE - x2 / 110;
        t = Q30_ONE - ((x2 * t) >> 30) / 72;
        t = Q30_ONE - ((x2 * t) >> 30) / 42;
        t = Q30_ONE - ((x2 * t) >> 30) / 20;
        t = Q30_ONE - ((x2 * t) >> 30) / 6;
        s = (x * t) >> 30;
        m = (((win * s) >> 30) + (64'd1 << 14)) >> 15;
        if (m > 64'd32767) m = 64'd32767;
        return q[1] ? -COEF_W'(m) : COEF_W'(m);
    endfunction

    function automatic t_coef_rom build_rom(input logic right);
        t_coef_rom rom;
        longint unsigned z;
        longint unsigned lin;
        longint unsigned win;
        longint unsigned ph;
        for (int i = 0; i < TAPS; i++) begin
            z   = (64'(3 * i) << 30) / 64'(16 * TAPS);
            lin = (64'(TAPS - i) << 30) / 64'(TAPS);
            win = (exp_neg16(z) * lin) >> 30;
            ph  = ((64'(i) + 64'd1) << 31) / 64'(TAPS + 1);
            if (right) ph = (ph + RIGHT_PHASE) & 64'hFFFF_FFFF;
            rom[i] = make_coef(win, ph);
        end
        return rom;
    endfunction

    localparam t_coef_rom COEF_LEFT  = build_rom(1'b0);
    localparam t_coef_rom COEF_RIGHT = build_rom(1'b1);

endpackage
`default_nettype wire

@@ sv/stereo_hrtf_fir_widener.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_hrtf_fir_widener
// Shelf recursion, 128-tap FIR per channel and wet/dry mix of a stereo pair.
// ----------------------------------------------------------------------------
// One stereo pair is taken per transfer and one pair comes back. An item goes
// from input transfer to result through the shelf step and the history write,
// one read per tap from the single-port history memory feeding one
// multiply-accumulate per channel, a short pipeline drain, then rounding and
// a two-step mix; the history memory read port sets how long that takes.
// Input is stalled for the whole item; the result sits in an output register
// so the next item can start while it waits. A sample_rate write with a new
// value clears the histories through per-entry valid bits (no clearing pass).
module stereo_hrtf_fir_widener (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_wr_en,
    input  wire                                 i_cfg_addr,
    input  wire  [shw_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  signed [shw_pkg::SAMPLE_BITS-1:0] i_left_sample,
    input  wire  signed [shw_pkg::SAMPLE_BITS-1:0] i_right_sample,
    input  wire                                 i_vocal_content,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic signed [shw_pkg::SAMPLE_BITS-1:0] o_left_out,
    output logic signed [shw_pkg::SAMPLE_BITS-1:0] o_right_out
);
    import shw_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SHELF, ST_MAC, ST_ROUND, ST_MIX1, ST_MIX2, ST_OUT
    } t_state;

    localparam int PROD_W = SAMPLE_BITS + COEF_W;
    localparam int MIX_W  = SAMPLE_BITS + WIDTH_W + 3;
    localparam int SH_W   = SAMPLE_BITS + 16;

    t_state r_state;

    logic [WIDTH_W-1:0] r_width;
    logic [RATE_W-1:0]  r_rate;

    logic signed [SAMPLE_BITS-1:0] r_xl, r_xr, r_shl, r_shr;
    logic                          r_vocal;
    logic [ADDR_W-1:0]             r_wp;
    logic [ADDR_W:0]               r_cnt;
    logic [TAPS-1:0]               r_hist_ok;

    logic                          r_rd_vld, r_rd_ok;
    logic [ADDR_W-1:0]             r_rd_tap;
    logic                          r_p_vld;
    logic signed [PROD_W-1:0]      r_pl, r_pr;
    logic signed [ACC_W-1:0]       r_accl, r_accr;
    logic signed [SAMPLE_BITS-1:0] r_fl, r_fr;
    logic signed [MIX_W-1:0]       r_ml, r_mr;
    logic [WIDTH_W:0]              r_w;

    // history memories
    logic signed [SAMPLE_BITS-1:0] r_mem_l [TAPS];
    logic signed [SAMPLE_BITS-1:0] r_mem_r [TAPS];
    logic signed [SAMPLE_BITS-1:0] r_ql, r_qr;

    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_addr;
    logic signed [SAMPLE_BITS-1:0] yl, yr;
    logic                          rd_issue;
    logic                          rate_clear;

    function automatic logic signed [SAMPLE_BITS-1:0] shelf_step(
        input logic signed [SAMPLE_BITS-1:0] x,
        input logic signed [SAMPLE_BITS-1:0] st
    );
        logic signed [SAMPLE_BITS:0] d;
        logic signed [SH_W-1:0]      p;
        logic signed [SAT_W-1:0]     s;
        d = (SAMPLE_BITS+1)'(x) - (SAMPLE_BITS+1)'(st);
        p = $signed({1'b0, SHELF_K}) * SH_W'(d) + SH_W'(16384);
        s = SAT_W'(x) + SAT_W'(p >>> 15);
        return $signed(sat_sample(s));
    endfunction

    assign o_in_stall = (r_state != ST_IDLE);
    assign yl = r_vocal ? r_xl : shelf_step(r_xl, r_shl);
    assign yr = r_vocal ? r_xr : shelf_step(r_xr, r_shr);
    assign rd_issue = (r_state == ST_MAC) && !r_cnt[ADDR_W];
    assign mem_we = (r_state == ST_SHELF);
    assign mem_addr = mem_we ? r_wp : r_wp - r_cnt[ADDR_W-1:0];
    assign rate_clear = i_cfg_wr_en && (i_cfg_addr == CFG_RATE)
                        && (i_cfg_wdata[RATE_W-1:0] != r_rate);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_l[mem_addr] <= yl;
            r_mem_r[mem_addr] <= yr;
        end
        r_ql <= r_mem_l[mem_addr];
        r_qr <= r_mem_r[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= '0;
            r_rate      <= RATE_RESET;
            r_shl       <= '0;
            r_shr       <= '0;
            r_wp        <= '0;
            r_cnt       <= '0;
            r_hist_ok   <= '0;
            r_rd_vld    <= 1'b0;
            r_p_vld     <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) o_out_valid <= 1'b0;

            r_rd_vld <= rd_issue;
            r_rd_ok  <= r_hist_ok[mem_addr];
            r_rd_tap <= r_cnt[ADDR_W-1:0];
            r_p_vld  <= r_rd_vld;
            r_pl     <= r_rd_ok ? PROD_W'(r_ql * COEF_LEFT[r_rd_tap])  : '0;
            r_pr     <= r_rd_ok ? PROD_W'(r_qr * COEF_RIGHT[r_rd_tap]) : '0;
            if (r_p_vld) begin
                r_accl <= r_accl + ACC_W'(r_pl);
                r_accr <= r_accr + ACC_W'(r_pr);
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_xl    <= i_left_sample;
                        r_xr    <= i_right_sample;
                        r_vocal <= i_vocal_content;
                        r_w     <= ({1'b0, r_width} > WIDTH_FULL) ? WIDTH_FULL
                                                                  : {1'b0, r_width};
                        r_state <= ST_SHELF;
                    end
                end
                ST_SHELF: begin
                    r_xl <= yl;
                    r_xr <= yr;
                    if (!r_vocal) begin
                        r_shl <= yl;
                        r_shr <= yr;
                    end
                    r_hist_ok[r_wp] <= 1'b1;
                    r_cnt   <= '0;
                    r_accl  <= '0;
                    r_accr  <= '0;
                    r_state <= ST_MAC;
                end
                ST_MAC: begin
                    if (!r_cnt[ADDR_W]) r_cnt <= r_cnt + 1'b1;
                    else if (!r_rd_vld && !r_p_vld) r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    r_fl    <= $signed(sat_sample((SAT_W'(r_accl) + SAT_W'(16384)) >>> 15));
                    r_fr    <= $signed(sat_sample((SAT_W'(r_accr) + SAT_W'(16384)) >>> 15));
                    r_wp    <= r_wp + 1'b1;
                    r_state <= ST_MIX1;
                end
                ST_MIX1: begin
                    r_ml    <= MIX_W'(r_xl * $signed({1'b0, WIDTH_FULL - r_w}));
                    r_mr    <= MIX_W'(r_xr * $signed({1'b0, WIDTH_FULL - r_w}));
                    r_state <= ST_MIX2;
                end
                ST_MIX2: begin
                    r_ml    <= r_ml + MIX_W'(r_fl * $signed({1'b0, r_w}))
                               + MIX_W'(16384);
                    r_mr    <= r_mr + MIX_W'(r_fr * $signed({1'b0, r_w}))
                               + MIX_W'(16384);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!o_out_valid || !i_out_stall) begin
                        o_left_out  <= $signed(sat_sample(SAT_W'(r_ml >>> 15)));
                        o_right_out <= $signed(sat_sample(SAT_W'(r_mr >>> 15)));
                        o_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if (i_cfg_wr_en && i_cfg_addr == CFG_WIDTH) r_width <= i_cfg_wdata[WIDTH_W-1:0];
            // new rate clears histories and shelf states
            if (rate_clear) begin
                r_rate    <= i_cfg_wdata[RATE_W-1:0];
                r_hist_ok <= '0;
                r_wp      <= '0;
                r_shl     <= '0;
                r_shr     <= '0;
            end
        end
    end

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> o_in_stall)
        else $error("input not stalled while busy");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == ST_SHELF))
        else $error("accepted transfer did not start the shelf step");

    a_rate_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rate_clear |=> (r_hist_ok == '0 && r_wp == '0))
        else $error("rate change did not clear history");

endmodule
`default_nettype wire
